@@ rtl/core/rpcc_pkg.sv @@
// Shared types, constants and helpers for the box region centroid block.
package rpcc_pkg;
    localparam int unsigned MaxFramePoints = 1048575;
    localparam int unsigned CountW = 20;
    localparam logic [CountW-1:0] CountCap =
        (MaxFramePoints < 1048575) ? CountW'(MaxFramePoints) : 20'hFFFFF;

    localparam logic [2:0] RegRowX = 3'd0;
    localparam logic [2:0] RegRowY = 3'd1;
    localparam logic [2:0] RegRowZ = 3'd2;
    localparam logic [2:0] RegBoxX = 3'd3;
    localparam logic [2:0] RegBoxY = 3'd4;
    localparam logic [2:0] RegBoxZ = 3'd5;
    localparam logic [2:0] RegThr  = 3'd6;

    localparam logic KindPoint   = 1'b0;
    localparam logic KindSummary = 1'b1;

    typedef struct packed {
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [19:0] point_z;
        logic               point_valid;
        logic               frame_end;
    } t_in_word;

    typedef struct packed {
        logic               result_kind;
        logic signed [19:0] out_x;
        logic signed [19:0] out_y;
        logic signed [19:0] out_z;
        logic               detected;
        logic [19:0]        region_count;
        logic               last;
    } t_out_word;

    // Front to back: one classified point.
    typedef struct packed {
        logic               in_box;
        logic               frame_end;
        logic signed [19:0] tx;
        logic signed [19:0] ty;
        logic signed [19:0] tz;
    } t_cls_word;

    function automatic logic signed [19:0] sat20(input logic signed [41:0] v);
        if (v > 42'sd524287) return 20'sd524287;
        if (v < -42'sd524288) return -20'sd524288;
        return v[19:0];
    endfunction
endpackage

@@ rtl/core/rpcc_if.sv @@
// Valid/ready channel carrying one word of type t.
interface rpcc_if #(parameter type t = logic) ();
    logic valid;
    logic ready;
    t     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rpcc_front.sv @@
// Front: affine transform, rounding, saturation and box test, two stages.
module rpcc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [63:0]          i_row [3],
    input  logic [39:0]          i_box [3],
    rpcc_if.sink                 s_in,
    output logic                 o_valid,
    output rpcc_pkg::t_cls_word  o_cls,
    input  logic                 i_ready
);
    logic r_v1, r_fe1, r_pv1;
    logic signed [35:0] r_p [3][3];
    logic signed [19:0] r_off [3];
    logic r_v2;
    rpcc_pkg::t_cls_word r_cls;
    logic adv1, adv2;
    logic signed [19:0] n_t [3];
    logic n_in [3];
    logic signed [41:0] acc [3];

    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign s_in.ready = adv1;
    assign o_valid = r_v2;
    assign o_cls = r_cls;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc[a] = 42'(r_p[a][0]) + 42'(r_p[a][1]) + 42'(r_p[a][2])
                   + (42'(r_off[a]) <<< 14) + 42'sd8192;
            n_t[a] = rpcc_pkg::sat20(acc[a] >>> 14);
            n_in[a] = (n_t[a] > $signed(i_box[a][19:0]))
                   && (n_t[a] < $signed(i_box[a][39:20]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= s_in.valid;
                r_fe1 <= s_in.data.frame_end;
                r_pv1 <= s_in.data.point_valid;
                for (int a = 0; a < 3; a++) begin
                    r_p[a][0] <= $signed(i_row[a][15:0]) * s_in.data.point_x;
                    r_p[a][1] <= $signed(i_row[a][31:16]) * s_in.data.point_y;
                    r_p[a][2] <= $signed(i_row[a][47:32]) * s_in.data.point_z;
                    r_off[a] <= 20'($signed(i_row[a][63:48]));
                end
            end
            if (adv2) begin
                r_v2 <= r_v1;
                r_cls.in_box <= r_pv1 && n_in[0] && n_in[1] && n_in[2];
                r_cls.frame_end <= r_fe1;
                r_cls.tx <= n_t[0];
                r_cls.ty <= n_t[1];
                r_cls.tz <= n_t[2];
            end
        end
    end
endmodule

@@ rtl/core/rpcc_queue.sv @@
// Four-entry queue between front and back.
module rpcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rpcc_pkg::t_cls_word i_word,
    output logic                o_ready,
    output logic                o_valid,
    output rpcc_pkg::t_cls_word o_word,
    input  logic                i_ready
);
    rpcc_pkg::t_cls_word r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_word = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_word;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end
endmodule

@@ rtl/core/rpcc_div.sv @@
// Restoring divider: 40-bit magnitude by 20-bit count, one bit a cycle.
module rpcc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [19:0] i_den,
    output logic        o_busy,
    output logic [39:0] o_quo
);
    logic [5:0]  r_cnt;
    logic [39:0] r_q;
    logic [20:0] r_rem;
    logic [19:0] r_den;
    logic [20:0] sh;
    logic [21:0] diff;

    assign o_busy = r_cnt != 6'd0;
    assign o_quo = r_q;
    assign sh = {r_rem[19:0], r_q[39]};
    assign diff = {1'b0, sh} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd40;
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (!diff[21]) begin
                r_rem <= diff[20:0];
                r_q <= {r_q[38:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q <= {r_q[38:0], 1'b0};
            end
        end
    end
endmodule

@@ rtl/core/rpcc_back.sv @@
// Back: accumulate, emit point words, compute the frame summary.
module rpcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [19:0]         i_thr,
    input  logic                i_valid,
    input  rpcc_pkg::t_cls_word i_word,
    output logic                o_ready,
    rpcc_if.source              m_out
);
    typedef enum logic [2:0] {S_RUN, S_DIV, S_WAIT, S_SUM} t_state;
    t_state r_state;
    logic [19:0] r_cnt;
    logic signed [39:0] r_sum [3];
    logic signed [19:0] r_cen [3];
    logic [1:0] r_axis;
    logic r_det;
    logic r_ov;
    rpcc_pkg::t_out_word r_out;
    logic div_start, div_busy;
    logic [39:0] div_quo, div_num;
    logic signed [39:0] cur;
    logic take, out_free, pt_emit, set_ov;
    logic [19:0] n_cnt;
    logic signed [39:0] n_sum [3];
    logic signed [41:0] quo_s;

    assign m_out.valid = r_ov;
    assign m_out.data = r_out;
    assign out_free = !r_ov || m_out.ready;
    assign take = (r_state == S_RUN) && i_valid && out_free;
    assign o_ready = (r_state == S_RUN) && out_free;
    assign set_ov = (take && pt_emit) || ((r_state == S_SUM) && out_free);
    assign cur = r_sum[r_axis];
    assign div_num = cur[39] ? 40'(-cur) : cur;
    assign div_start = (r_state == S_DIV) && !div_busy;

    rpcc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_cnt), .o_busy(div_busy), .o_quo(div_quo)
    );

    assign quo_s = cur[39] ? -42'($signed({1'b0, div_quo})) : 42'($signed({1'b0, div_quo}));

    always_comb begin
        pt_emit = i_word.in_box;
        n_cnt = r_cnt;
        n_sum = r_sum;
        if (i_word.in_box && r_cnt < rpcc_pkg::CountCap) begin
            n_cnt = r_cnt + 20'd1;
            n_sum[0] = r_sum[0] + 40'(i_word.tx);
            n_sum[1] = r_sum[1] + 40'(i_word.ty);
            n_sum[2] = r_sum[2] + 40'(i_word.tz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_ov <= 1'b0;
            r_cnt <= '0;
            r_sum <= '{default: '0};
        end else begin
            if (set_ov) r_ov <= 1'b1;
            else if (m_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_RUN: if (take) begin
                    r_cnt <= n_cnt;
                    r_sum <= n_sum;
                    if (pt_emit) begin
                        r_out <= '{result_kind: rpcc_pkg::KindPoint,
                            out_x: i_word.tx, out_y: i_word.ty, out_z: i_word.tz,
                            detected: 1'b0, region_count: '0,
                            last: !i_word.frame_end};
                    end
                    if (i_word.frame_end) begin
                        r_axis <= '0;
                        r_det <= n_cnt > i_thr;
                        r_cen <= '{default: '0};
                        r_state <= (n_cnt > i_thr) ? S_DIV : S_SUM;
                    end
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: if (!div_busy) begin
                    r_cen[r_axis] <= rpcc_pkg::sat20(quo_s);
                    if (r_axis == 2'd2) r_state <= S_SUM;
                    else begin
                        r_axis <= r_axis + 2'd1;
                        r_state <= S_DIV;
                    end
                end
                S_SUM: if (out_free) begin
                    r_out <= '{result_kind: rpcc_pkg::KindSummary,
                        out_x: r_cen[0], out_y: r_cen[1], out_z: r_cen[2],
                        detected: r_det, region_count: r_cnt, last: 1'b1};
                    r_cnt <= '0;
                    r_sum <= '{default: '0};
                    r_state <= S_RUN;
                end
                default: r_state <= S_RUN;
            endcase
        end
    end
endmodule

@@ rtl/core/roi_point_count_centroid.sv @@
// Top level of the box region point counter and centroid block.
// Input channel s_in carries one lidar point word (x, y, z in mm, valid,
// frame end). Output channel m_out carries result words: a point word for
// each transformed point strictly inside the box, and a summary word on the
// frame's last point, after that point's own word.
// The front transforms in two pipeline stages (multiplies, then sum, round,
// saturate and box test) and writes into a four-word queue; the back then
// counts and sums. Points flow at one word a cycle when nothing stalls; a
// point word passes both front stages, the queue and the output register.
// A summary with detection runs three 40-step divisions on the shared
// divider, during which the back takes no word and the front fills the
// queue and then stalls. Without detection the summary needs no division.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; write only when idle.
// Synchronous reset restores register defaults and clears count and sums.
// When the receiver stalls, hold the output word; the queue absorbs input.
module roi_point_count_centroid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    rpcc_if.sink        s_in,
    rpcc_if.source      m_out
);
    logic [63:0] r_row [3];
    logic [39:0] r_box [3];
    logic [19:0] r_thr;
    logic f_valid, q_ready, q_valid, b_ready;
    rpcc_pkg::t_cls_word f_cls, q_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'h4000;
            r_row[1] <= 64'h4000_0000;
            r_row[2] <= 64'h4000_0000_0000;
            r_box[0] <= 40'd28835853000;
            r_box[1] <= 40'd4777312456;
            r_box[2] <= 40'd3145729700;
            r_thr <= 20'd40;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpcc_pkg::RegRowX: r_row[0] <= i_cfg_data;
                rpcc_pkg::RegRowY: r_row[1] <= i_cfg_data;
                rpcc_pkg::RegRowZ: r_row[2] <= i_cfg_data;
                rpcc_pkg::RegBoxX: r_box[0] <= i_cfg_data[39:0];
                rpcc_pkg::RegBoxY: r_box[1] <= i_cfg_data[39:0];
                rpcc_pkg::RegBoxZ: r_box[2] <= i_cfg_data[39:0];
                rpcc_pkg::RegThr:  r_thr <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    rpcc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_row(r_row), .i_box(r_box),
        .s_in(s_in), .o_valid(f_valid), .o_cls(f_cls), .i_ready(q_ready)
    );

    rpcc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_word(f_cls),
        .o_ready(q_ready), .o_valid(q_valid), .o_word(q_word), .i_ready(b_ready)
    );

    rpcc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_thr(r_thr), .i_valid(q_valid),
        .i_word(q_word), .o_ready(b_ready), .m_out(m_out)
    );

    // A stalled output word must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("output word changed under stall");
    // A point word never claims detection or a count.
    a_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.data.result_kind == rpcc_pkg::KindPoint |->
        !m_out.data.detected && m_out.data.region_count == '0)
        else $error("point word carries summary fields");
    // A summary is always the last word of its run.
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.data.result_kind == rpcc_pkg::KindSummary |->
        m_out.data.last)
        else $error("summary without last");
endmodule

@@ test/tb_top.sv @@
// Testbench for the box region point counter and centroid block.
`timescale 1ns / 100ps

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    rpcc_if #(.t(rpcc_pkg::t_in_word))  in_ch ();
    rpcc_if #(.t(rpcc_pkg::t_out_word)) out_ch ();

    roi_point_count_centroid u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    localparam int WatchdogLimit = 20000;
    // Index with no register behind it.
    localparam logic [2:0] RegUnused = 3'd7;

    // Predictor copy of the registers and frame state.
    logic [63:0] row_cfg [3];
    logic [39:0] box_cfg [3];
    logic [19:0] thr_cfg;
    logic [19:0] frame_count;
    longint      frame_sum [3];

    rpcc_pkg::t_in_word  pending_words [$];
    rpcc_pkg::t_out_word expected_words [$];

    int  fail_cnt;
    int  mismatch_cnt;
    int  idle_cnt;
    bit  no_idle;
    bit  hold_off;
    int  hold_cycles;
    bit  stim_done;
    bit  in_acc;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_pending(input rpcc_pkg::t_in_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void add_expected(input rpcc_pkg::t_out_word w);
        expected_words = {expected_words, w};
    endfunction

    function automatic longint sx(input logic [63:0] v, input int w);
        longint r;
        r = longint'(v << (64 - w));
        return r >>> (64 - w);
    endfunction

    function automatic longint sat_mm(input longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // Round half up via floor division by 2^14, then saturate.
    function automatic longint transform_axis(input logic [63:0] row, input longint x,
                                              input longint y, input longint z);
        longint acc;
        acc = sx(row, 16) * x + sx(row >> 16, 16) * y + sx(row >> 32, 16) * z
            + sx(row >> 48, 16) * 16384 + 8192;
        return sat_mm(acc >>> 14);
    endfunction

    task automatic predict_results(input rpcc_pkg::t_in_word w);
        longint              p [3];
        longint              t [3];
        longint              c [3];
        bit                  in_box;
        rpcc_pkg::t_out_word r;
        bit                  det;
        p[0] = w.point_x;
        p[1] = w.point_y;
        p[2] = w.point_z;
        if (w.point_valid) begin
            in_box = 1'b1;
            for (int a = 0; a < 3; a++) begin
                t[a] = transform_axis(row_cfg[a], p[0], p[1], p[2]);
                if (!(t[a] > sx(box_cfg[a], 20) && t[a] < sx(box_cfg[a] >> 20, 20)))
                    in_box = 1'b0;
            end
            if (in_box) begin
                r = '0;
                r.result_kind = rpcc_pkg::KindPoint;
                r.out_x = t[0][19:0];
                r.out_y = t[1][19:0];
                r.out_z = t[2][19:0];
                r.last = !w.frame_end;
                add_expected(r);
                if (frame_count < rpcc_pkg::CountCap) begin
                    frame_count++;
                    for (int a = 0; a < 3; a++) frame_sum[a] += t[a];
                end
            end
        end
        if (w.frame_end) begin
            det = frame_count > thr_cfg;
            r = '0;
            r.result_kind = rpcc_pkg::KindSummary;
            if (det && frame_count > 0) begin
                for (int a = 0; a < 3; a++)
                    c[a] = sat_mm(frame_sum[a] / longint'(frame_count));
                r.out_x = c[0][19:0];
                r.out_y = c[1][19:0];
                r.out_z = c[2][19:0];
            end
            r.detected = det;
            r.region_count = frame_count;
            r.last = 1'b1;
            add_expected(r);
            frame_count = '0;
            for (int a = 0; a < 3; a++) frame_sum[a] = 0;
        end
    endtask

    // Driver: hold an offered word until taken, otherwise offer the head
    // of the pending queue, idling at random.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_acc) begin
                if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_words[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls unless no_idle is set.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off && hold_cycles < 400) begin
                hold_cycles++;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_idle || $urandom_range(99) >= 10;
            end
        end
    end

    // Monitor: record accepted inputs, compare each accepted result with
    // the oldest expectation.
    always @(posedge i_clk) begin
        rpcc_pkg::t_out_word e;
        in_acc = 1'b0;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result word %h", out_ch.data);
                end else begin
                    e = expected_words.pop_front();
                    if (out_ch.data !== e) begin
                        fail_cnt++;
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: expected %p actual %p", e, out_ch.data);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                in_acc = 1'b1;
                predict_results(in_ch.data);
                void'(pending_words.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            rpcc_pkg::RegRowX: row_cfg[0] = val;
            rpcc_pkg::RegRowY: row_cfg[1] = val;
            rpcc_pkg::RegRowZ: row_cfg[2] = val;
            rpcc_pkg::RegBoxX: box_cfg[0] = val[39:0];
            rpcc_pkg::RegBoxY: box_cfg[1] = val[39:0];
            rpcc_pkg::RegBoxZ: box_cfg[2] = val[39:0];
            rpcc_pkg::RegThr:  thr_cfg    = val[19:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [39:0] pack_box(input int lo, input int hi);
        return {20'(hi), 20'(lo)};
    endfunction

    function automatic logic [63:0] pack_row(input int cx, input int cy, input int cz,
                                             input int off);
        return {16'(off), 16'(cz), 16'(cy), 16'(cx)};
    endfunction

    // Wait for the block to drain, plus a margin for a pending division.
    task automatic drain;
        while (pending_words.size() > 0 || expected_words.size() > 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic rpcc_pkg::t_in_word make_point(input int x, input int y, input int z,
                                                      input bit v, input bit fe);
        rpcc_pkg::t_in_word w;
        w.point_x = 20'(x);
        w.point_y = 20'(y);
        w.point_z = 20'(z);
        w.point_valid = v;
        w.frame_end = fe;
        return w;
    endfunction

    // Random frame: mostly points near the box, some anywhere, some invalid.
    task automatic queue_frame(input int npts, input int cx, input int cy, input int cz,
                               input int spread);
        rpcc_pkg::t_in_word w;
        for (int i = 0; i < npts; i++) begin
            if ($urandom_range(9) == 0)
                w = rpcc_pkg::t_in_word'(62'({$urandom, $urandom}));
            else
                w = make_point(cx + $urandom_range(2 * spread) - spread,
                               cy + $urandom_range(2 * spread) - spread,
                               cz + $urandom_range(2 * spread) - spread,
                               $urandom_range(15) != 0, 1'b0);
            w.frame_end = (i == npts - 1);
            add_pending(w);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        fail_cnt = 0;
        mismatch_cnt = 0;
        idle_cnt = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        stim_done = 1'b0;
        in_acc = 1'b0;
        row_cfg[0] = 64'h4000;
        row_cfg[1] = 64'h4000_0000;
        row_cfg[2] = 64'h4000_0000_0000;
        box_cfg[0] = 40'd28835853000;
        box_cfg[1] = 40'd4777312456;
        box_cfg[2] = 40'd3145729700;
        thr_cfg = 20'd40;
        frame_count = '0;
        for (int a = 0; a < 3; a++) frame_sum[a] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, field extremes, invalid point, empty frame.
        add_pending(make_point(20000, 1000, 2000, 1, 0));
        add_pending(make_point(20000, 1000, 2000, 1, 1));
        add_pending(make_point(524287, 524287, 524287, 1, 0));
        add_pending(make_point(-524288, -524288, -524288, 1, 0));
        add_pending(make_point(20000, 1000, 2000, 0, 1));
        add_pending(make_point(0, 0, 0, 0, 1));
        add_pending(make_point(13000, 200, 1700, 1, 0));
        add_pending(make_point(13001, 201, 1701, 1, 0));
        add_pending(make_point(27499, 4555, 2999, 1, 1));
        drain();

        // Threshold 0: a single inside point is detected.
        write_reg(rpcc_pkg::RegThr, 64'd0);
        add_pending(make_point(20001, 1001, 2001, 1, 1));
        add_pending(make_point(-1, -1, -1, 1, 1));
        drain();

        // Full-scale rotation and offsets, huge box: saturation both ways.
        write_reg(rpcc_pkg::RegRowX, pack_row(32767, 32767, 32767, 32767));
        write_reg(rpcc_pkg::RegRowY, pack_row(-32768, -32768, -32768, -32768));
        write_reg(rpcc_pkg::RegRowZ, pack_row(-16384, 8192, 1, -1));
        write_reg(rpcc_pkg::RegBoxX, pack_box(-524288, 524287));
        write_reg(rpcc_pkg::RegBoxY, pack_box(-524288, 524287));
        write_reg(rpcc_pkg::RegBoxZ, pack_box(-524288, 524287));
        write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
        add_pending(make_point(524287, 524287, 524287, 1, 0));
        add_pending(make_point(-524288, -524288, -524288, 1, 0));
        add_pending(make_point(3, -2, 1, 1, 0));
        add_pending(make_point(1, 1, 1, 1, 1));
        drain();

        // Random phases over several transform, box and threshold settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(rpcc_pkg::RegRowX, pack_row(16384 + $urandom_range(4000) - 2000,
                                                  $urandom_range(4000) - 2000,
                                                  $urandom_range(4000) - 2000,
                                                  $urandom_range(2000) - 1000));
            write_reg(rpcc_pkg::RegRowY, pack_row($urandom_range(4000) - 2000,
                                                  16384 + $urandom_range(4000) - 2000,
                                                  $urandom_range(4000) - 2000,
                                                  $urandom_range(2000) - 1000));
            write_reg(rpcc_pkg::RegRowZ, pack_row($urandom_range(4000) - 2000,
                                                  $urandom_range(4000) - 2000,
                                                  (ph == 5) ? -32768 : 16384,
                                                  $urandom_range(2000) - 1000));
            write_reg(rpcc_pkg::RegBoxX, pack_box(-3000, 3000));
            write_reg(rpcc_pkg::RegBoxY, pack_box(-2500, 2500));
            write_reg(rpcc_pkg::RegBoxZ,
                      (ph == 5) ? pack_box(-524288, 524287) : pack_box(-2000, 2000));
            write_reg(rpcc_pkg::RegThr, (ph == 4) ? 64'hFFFFF : 64'($urandom_range(30)));
            no_idle = (ph == 2);
            hold_off = (ph == 3);
            hold_cycles = 0;
            for (int f = 0; f < 5; f++)
                queue_frame(1 + $urandom_range(60), 0, 0, 0, 3500);
            drain();
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (fail_cnt == 0 && expected_words.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        wait (idle_cnt >= WatchdogLimit);
        $display("tb_top failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/rpcc_pkg.sv
rtl/core/rpcc_if.sv
rtl/core/rpcc_front.sv
rtl/core/rpcc_queue.sv
rtl/core/rpcc_div.sv
rtl/core/rpcc_back.sv
rtl/core/roi_point_count_centroid.sv
test/tb_top.sv
